>>> design/ple_pkg.sv
// Package for the positional list engine: action codes and result word type.
// Used by ple_core and positional_list_engine_top.
`default_nettype none
package ple_pkg;
    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_WRITE  = 3'd1;
    localparam logic [2:0] ACT_INSERT = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_FIND   = 3'd4;

    typedef struct packed {
        logic [6:0]  list_length;
        logic [5:0]  found_index;
        logic [31:0] read_value;
        logic        ok;
    } result_t;
endpackage
`default_nettype wire

>>> design/positional_list_engine_top.sv
// Positional list engine: ordered list of signed values addressed by position.
// Insert and remove shift entries and find scans them through the entry memory,
// which moves or compares one entry per cycle. One request in flight; a new
// one waits until the pending result word is taken.
// rst_n clears the list length; stored entries are not cleared.
`default_nettype none
module positional_list_engine_top #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // action[2:0], position[9:3], value_in[41:10]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata   // ok[0], read_value[32:1], found_index[38:33],
                                       // list_length[45:39]
);
    logic             busy;
    logic             done;
    logic             start;
    ple_pkg::result_t res;
    logic [45:0]      out_reg;
    logic             out_valid_reg;

    assign s_tready = !busy && (!out_valid_reg || m_tready);
    assign start    = s_tvalid && s_tready;

    ple_core #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .action   (s_tdata[2:0]),
        .position (s_tdata[9:3]),
        .value_in (s_tdata[41:10]),
        .busy     (busy),
        .done     (done),
        .result   (res)
    );

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= {res.list_length, res.found_index, res.read_value, res.ok};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};
endmodule
`default_nettype wire

>>> design/ple_core.sv
// Sequencer and entry memory for the positional list engine.
// Depends on ple_pkg for action codes and the result type.
`default_nettype none
module ple_core #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        action,
    input  wire logic [6:0]        position,
    input  wire logic [31:0]       value_in,
    output logic                   busy,
    output logic                   done,
    output ple_pkg::result_t       result
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [2:0]            act_reg, act_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [CW-1:0]         idx_reg, idx_next;   // scan or shift cursor
    logic                  ok_reg, ok_next;
    logic [31:0]           rd_reg, rd_next;
    logic [5:0]            fidx_reg, fidx_next;

    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic [VALUE_BITS-1:0] val_cut;
    logic [63:0]           rd_wide;

    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(count_reg);
    assign val_cut = VALUE_BITS'({{32{value_in[31]}}, value_in});
    assign rd_wide = 64'({{64{rdata_reg[VALUE_BITS-1]}}, rdata_reg});

    // Entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        ok_reg   <= ok_next;
        rd_reg   <= rd_next;
        fidx_reg <= fidx_next;
    end

    // Sequencer: read, shift or scan through the memory one entry a cycle
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        act_next   = act_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        ok_next    = ok_reg;
        rd_next    = rd_reg;
        fidx_next  = fidx_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[AW-1:0];
        mem_wdata  = val_reg;
        mem_raddr  = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next  = action;
                    pos_next  = pos_ext;
                    val_next  = val_cut;
                    ok_next   = 1'b0;
                    rd_next   = '0;
                    fidx_next = '0;
                    state_next = ST_DONE;
                    unique case (action)
                        ple_pkg::ACT_READ, ple_pkg::ACT_REMOVE:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                mem_raddr  = pos_ext[AW-1:0];
                                idx_next   = CW'(pos_ext);
                                state_next = ST_READ;
                            end
                        end
                        ple_pkg::ACT_WRITE:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_ext[AW-1:0];
                                mem_wdata = val_cut;
                                ok_next   = 1'b1;
                            end
                        end
                        ple_pkg::ACT_INSERT:
                        begin
                            if (pos_ext <= cnt_ext && count_reg < CW'(CAPACITY))
                            begin
                                ok_next = 1'b1;
                                if (pos_ext == cnt_ext)
                                begin
                                    mem_we     = 1'b1;
                                    mem_waddr  = count_reg[AW-1:0];
                                    mem_wdata  = val_cut;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    // read entry count-1, write it one up next
                                    idx_next   = count_reg - 1'b1;
                                    mem_raddr  = AW'(count_reg - 1'b1);
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        ple_pkg::ACT_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rd_next = rd_wide[31:0];
                ok_next = 1'b1;
                if (act_reg == ple_pkg::ACT_REMOVE)
                begin
                    if (idx_reg + 1'b1 < count_reg)
                    begin
                        // prefetch next entry and move it down
                        mem_raddr  = AW'(idx_reg + 1'b1);
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                mem_we = 1'b1;
                mem_wdata = rdata_reg;
                if (act_reg == ple_pkg::ACT_INSERT)
                begin
                    // rdata holds entry idx; move it to idx+1
                    mem_waddr = AW'(idx_reg + 1'b1);
                    if (PW'(idx_reg) == pos_reg)
                    begin
                        state_next = ST_DONE;
                        count_next = count_reg + 1'b1;
                        // value itself lands at pos in ST_DONE
                    end
                    else
                    begin
                        idx_next  = idx_reg - 1'b1;
                        mem_raddr = AW'(idx_reg - 1'b1);
                    end
                end
                else
                begin
                    // remove: rdata holds entry idx; move it to idx-1
                    mem_waddr = AW'(idx_reg - 1'b1);
                    if (idx_reg + 1'b1 < count_reg)
                    begin
                        idx_next  = idx_reg + 1'b1;
                        mem_raddr = AW'(idx_reg + 1'b1);
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rdata_reg == val_reg)
                begin
                    ok_next    = 1'b1;
                    fidx_next  = 6'(idx_reg);
                    state_next = ST_DONE;
                end
                else if (idx_reg + 1'b1 < count_reg)
                begin
                    idx_next  = idx_reg + 1'b1;
                    mem_raddr = AW'(idx_reg + 1'b1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // insert with shifting writes the new value last
                if (act_reg == ple_pkg::ACT_INSERT && ok_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg[AW-1:0];
                    mem_wdata = val_reg;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign result.ok          = ok_reg;
    assign result.read_value  = rd_reg;
    assign result.found_index = fidx_reg;
    assign result.list_length = 7'(count_reg);
endmodule
`default_nettype wire
